[sv/ccpo_pkg.sv]
// ----------------------------------------------------------------------------
// ccpo_pkg: shared types and widths for the cylinder push-out unit
// Holds the coordinate width, derived internal widths and the payload
// structs that travel through the front stages and the cell chains.
// ----------------------------------------------------------------------------
package ccpo_pkg;

	// Coordinate width of the ports.
	localparam int W    = 32;
	// Magnitude of a coordinate difference.
	localparam int MW   = W + 1;
	// Sum of two squared magnitudes.
	localparam int SW   = 2 * MW;
	// Integer square root of that sum.
	localparam int DW   = MW;
	// Magnitude times summed radius.
	localparam int PW   = MW + W;
	// Division numerator with the rounding term added.
	localparam int NW   = PW + 1;
	// Quotient width of the push distance.
	localparam int QW   = W;
	localparam int DIDX = $clog2(DW);
	localparam int QIDX = $clog2(QW);

	// Per-transaction fields carried beside the arithmetic.
	typedef struct packed {
		logic signed [W-1:0] ax;
		logic signed [W-1:0] az;
		logic signed [W-1:0] bx;
		logic signed [W-1:0] by;
		logic signed [W-1:0] bz;
		logic [W-1:0]        range;
		logic                height_ok;
		logic                dist_ok;
		logic                coinc;
		logic                sx;
		logic                sz;
	} side_t;

	// Payload of one square-root cell.
	typedef struct packed {
		side_t          side;
		logic [SW-1:0]  rem;
		logic [DW-1:0]  root;
		logic [PW-1:0]  pdx;
		logic [PW-1:0]  pdz;
	} sq_t;

	// Payload of one division cell (x and z lanes side by side).
	typedef struct packed {
		side_t          side;
		logic [DW-1:0]  d;
		logic [NW-1:0]  nx;
		logic [NW-1:0]  nz;
		logic [QW-1:0]  qx;
		logic [QW-1:0]  qz;
	} dv_t;

endpackage

[sv/ccpo_front.sv]
// ----------------------------------------------------------------------------
// ccpo_front: difference, product and distance-test stages
// Forms the XZ differences, the height test, the squared distance, the
// squared radius sum and the push numerators over four pipeline stages.
// ----------------------------------------------------------------------------
module ccpo_front import ccpo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic signed [W-1:0] a_x,
	input  logic signed [W-1:0] a_y,
	input  logic signed [W-1:0] a_z,
	input  logic [W-2:0]        a_radius,
	input  logic [W-2:0]        a_height,
	input  logic signed [W-1:0] b_x,
	input  logic signed [W-1:0] b_y,
	input  logic signed [W-1:0] b_z,
	input  logic [W-2:0]        b_radius,
	input  logic [W-2:0]        b_height,
	output logic                out_v,
	output sq_t                 out_d
);

	logic signed [W:0] dx, dz, a_top, b_top, ay_e, by_e;
	logic [MW-1:0]     mx, mz;
	side_t             side_c;

	logic              v_s1, v_s2, v_s3, v_s4;
	side_t             side_s1, side_s2, side_s3;
	logic [MW-1:0]     mx_s1, mz_s1;
	logic [SW-1:0]     sqx_s2, sqz_s2, s_s3;
	logic [2*W-1:0]    r2_s2, r2_s3;
	logic [PW-1:0]     pdx_s2, pdz_s2, pdx_s3, pdz_s3;
	sq_t               out_c;
	sq_t               out_s4;

	// Differences, magnitudes and the height overlap test.
	always_comb begin
		dx    = {b_x[W-1], b_x} - {a_x[W-1], a_x};
		dz    = {b_z[W-1], b_z} - {a_z[W-1], a_z};
		mx    = dx[W] ? MW'(-dx) : MW'(dx);
		mz    = dz[W] ? MW'(-dz) : MW'(dz);
		ay_e  = {a_y[W-1], a_y};
		by_e  = {b_y[W-1], b_y};
		a_top = ay_e + $signed({2'b00, a_height});
		b_top = by_e + $signed({2'b00, b_height});
		side_c.ax        = a_x;
		side_c.az        = a_z;
		side_c.bx        = b_x;
		side_c.by        = b_y;
		side_c.bz        = b_z;
		side_c.range     = {1'b0, a_radius} + {1'b0, b_radius};
		side_c.height_ok = !((ay_e > b_top) || (a_top < by_e));
		side_c.dist_ok   = 1'b0;
		side_c.coinc     = (dx == '0) && (dz == '0);
		side_c.sx        = dx[W];
		side_c.sz        = dz[W];
	end

	// Radius compare and the payload handed to the square-root chain.
	always_comb begin
		out_c              = '0;
		out_c.side         = side_s3;
		out_c.side.dist_ok = s_s3 <= SW'(r2_s3);
		out_c.rem          = s_s3;
		out_c.pdx          = pdx_s3;
		out_c.pdz          = pdz_s3;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage payloads: products, then the sum, then the radius compare.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			mx_s1   <= mx;
			mz_s1   <= mz;

			side_s2 <= side_s1;
			sqx_s2  <= mx_s1 * mx_s1;
			sqz_s2  <= mz_s1 * mz_s1;
			r2_s2   <= side_s1.range * side_s1.range;
			pdx_s2  <= mx_s1 * side_s1.range;
			pdz_s2  <= mz_s1 * side_s1.range;

			side_s3 <= side_s2;
			s_s3    <= sqx_s2 + sqz_s2;
			r2_s3   <= r2_s2;
			pdx_s3  <= pdx_s2;
			pdz_s3  <= pdz_s2;

			out_s4  <= out_c;
		end
	end

	assign out_v = v_s4;
	assign out_d = out_s4;

endmodule

[sv/ccpo_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// ccpo_sqrt_cell: one bit of the integer square root
// Tries one root bit against the running remainder and hands the updated
// remainder and root to the next cell.
// ----------------------------------------------------------------------------
module ccpo_sqrt_cell import ccpo_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [DIDX-1:0] bit_idx,
	input  logic            in_v,
	input  sq_t             in_d,
	output logic            out_v,
	output sq_t             out_d
);

	logic [SW:0] trial;
	logic        take;
	sq_t         nxt;
	logic        v_q;
	sq_t         d_q;

	// Trial subtrahend is (2*root + 2^k) * 2^k; root holds only bits above k.
	always_comb begin
		trial = ((SW+1)'(in_d.root) << ({1'b0, bit_idx} + 1'b1))
			| ((SW+1)'(1) << {bit_idx, 1'b0});
		take  = {1'b0, in_d.rem} >= trial;
		nxt   = in_d;
		if (take) begin
			nxt.rem  = in_d.rem - trial[SW-1:0];
			nxt.root = in_d.root | (DW'(1) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

endmodule

[sv/ccpo_div_cell.sv]
// ----------------------------------------------------------------------------
// ccpo_div_cell: one quotient bit for the x and z push divisions
// Compares both residuals against the shifted root and hands the reduced
// residuals and quotients to the next cell.
// ----------------------------------------------------------------------------
module ccpo_div_cell import ccpo_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [QIDX-1:0] bit_idx,
	input  logic            in_v,
	input  dv_t             in_d,
	output logic            out_v,
	output dv_t             out_d
);

	logic [NW-1:0] dsh;
	dv_t           nxt;
	logic          v_q;
	dv_t           d_q;

	// Restoring step on both lanes.
	always_comb begin
		dsh = NW'(in_d.d) << bit_idx;
		nxt = in_d;
		if (in_d.nx >= dsh) begin
			nxt.nx = in_d.nx - dsh;
			nxt.qx = in_d.qx | (QW'(1) << bit_idx);
		end
		if (in_d.nz >= dsh) begin
			nxt.nz = in_d.nz - dsh;
			nxt.qz = in_d.qz | (QW'(1) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign out_d = d_q;

endmodule

[sv/cylinder_cylinder_push_out_unit.sv]
// ----------------------------------------------------------------------------
// cylinder_cylinder_push_out_unit: upright cylinder pair collision resolver
// Takes two cylinders per transaction and returns B's resolved position.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries cylinders A and B, each as
//   a signed Q15.16 base position and an unsigned Q15.16 radius and height.
//   The output channel (out_valid/out_ready) returns hit and B's position,
//   pushed out to the summed radius along the XZ direction from A to B on a hit.
//   Throughput is one transaction per cycle while the skid register is empty.
//   From acceptance to out_valid a transaction passes four front stages, 33
//   square-root cells, one numerator stage, 32 division cells, one output
//   formatting stage and the output register. The cell chains resolve one
//   root bit or one quotient bit per cell.
//   When the receiver stalls, the held result waits in the output register
//   and the next finished result drops into a one-entry skid register;
//   only then does the whole pipeline freeze and in_ready go low.
//   Reset clears all valid bits; the pipeline is empty and in_ready is high.
// ----------------------------------------------------------------------------
module cylinder_cylinder_push_out_unit import ccpo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W-1:0] a_x,
	input  logic signed [W-1:0] a_y,
	input  logic signed [W-1:0] a_z,
	input  logic [W-2:0]        a_radius,
	input  logic [W-2:0]        a_height,
	input  logic signed [W-1:0] b_x,
	input  logic signed [W-1:0] b_y,
	input  logic signed [W-1:0] b_z,
	input  logic [W-2:0]        b_radius,
	input  logic [W-2:0]        b_height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic signed [W-1:0] out_x,
	output logic signed [W-1:0] out_y,
	output logic signed [W-1:0] out_z
);

	typedef struct packed {
		logic                hit;
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic signed [W-1:0] z;
	} res_t;

	logic en;
	logic sq_v [DW+1];
	sq_t  sq_d [DW+1];
	logic dv_v [QW+1];
	dv_t  dv_d [QW+1];

	logic        num_v_s1;
	dv_t         num_s1;
	logic        fin_v_s2;
	res_t        fin_s2;
	res_t        fin_c;

	logic        out_v_q, skid_v_q;
	res_t        out_q, skid_q;
	logic        out_free;

	// The pipeline moves whenever the skid register is empty.
	assign en       = !skid_v_q;
	assign in_ready = en;

	ccpo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (in_valid),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.a_radius (a_radius),
		.a_height (a_height),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.b_radius (b_radius),
		.b_height (b_height),
		.out_v    (sq_v[0]),
		.out_d    (sq_d[0])
	);

	// Square-root chain, most significant root bit first.
	for (genvar i = 0; i < DW; i++) begin : g_sqrt
		ccpo_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.bit_idx (DIDX'(DW - 1 - i)),
			.in_v    (sq_v[i]),
			.in_d    (sq_d[i]),
			.out_v   (sq_v[i+1]),
			.out_d   (sq_d[i+1])
		);
	end

	// Numerators with the half-divisor rounding term.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_v_s1 <= 1'b0;
		end else if (en) begin
			num_v_s1 <= sq_v[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1.side <= sq_d[DW].side;
			num_s1.d    <= sq_d[DW].root;
			num_s1.nx   <= {1'b0, sq_d[DW].pdx} + NW'(sq_d[DW].root >> 1);
			num_s1.nz   <= {1'b0, sq_d[DW].pdz} + NW'(sq_d[DW].root >> 1);
			num_s1.qx   <= '0;
			num_s1.qz   <= '0;
		end
	end

	assign dv_v[0] = num_v_s1;
	assign dv_d[0] = num_s1;

	// Division chain, most significant quotient bit first.
	for (genvar i = 0; i < QW; i++) begin : g_div
		ccpo_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.bit_idx (QIDX'(QW - 1 - i)),
			.in_v    (dv_v[i]),
			.in_d    (dv_d[i]),
			.out_v   (dv_v[i+1]),
			.out_d   (dv_d[i+1])
		);
	end

	// Sign, offset from A, saturation, the coincident-center case and the miss bypass.
	always_comb begin
		logic [QW-1:0]       qx, qz;
		logic                sx, sz;
		logic signed [W+1:0] px, pz, sumx, sumz;
		logic signed [W-1:0] satx, satz;
		side_t               sd;
		sd = dv_d[QW].side;
		if (sd.coinc) begin
			qx = QW'(sd.range);
			qz = '0;
			sx = 1'b0;
			sz = 1'b0;
		end else begin
			qx = dv_d[QW].qx;
			qz = dv_d[QW].qz;
			sx = sd.sx;
			sz = sd.sz;
		end
		px   = sx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
		pz   = sz ? -$signed({2'b00, qz}) : $signed({2'b00, qz});
		sumx = $signed({{2{sd.ax[W-1]}}, sd.ax}) + px;
		sumz = $signed({{2{sd.az[W-1]}}, sd.az}) + pz;
		if (sumx[W+1:W-1] == 3'b000 || sumx[W+1:W-1] == 3'b111) begin
			satx = sumx[W-1:0];
		end else begin
			satx = sumx[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		if (sumz[W+1:W-1] == 3'b000 || sumz[W+1:W-1] == 3'b111) begin
			satz = sumz[W-1:0];
		end else begin
			satz = sumz[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		fin_c.hit = sd.height_ok && sd.dist_ok;
		fin_c.x   = fin_c.hit ? satx : sd.bx;
		fin_c.y   = sd.by;
		fin_c.z   = fin_c.hit ? satz : sd.bz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s2 <= 1'b0;
		end else if (en) begin
			fin_v_s2 <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s2 <= fin_c;
		end
	end

	// Output register with a one-entry skid register behind it.
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (fin_v_s2) begin
			if (out_free) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_free) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (fin_v_s2) begin
			if (out_free) begin
				out_q <= fin_s2;
			end else begin
				skid_q <= fin_s2;
			end
		end
	end

	assign out_valid = out_v_q;
	assign hit       = out_q.hit;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_z     = out_q.z;

	// The skid register only fills behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	// A drained skid entry moves out and does not refill in the same cycle.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && out_ready |=> out_v_q && !skid_v_q)
		else $error("skid register failed to drain");

	// A stalled, full skid register stays full and the pipeline holds still.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_ready |=> skid_v_q && $stable(fin_v_s2))
		else $error("pipeline moved while skid register was full");

endmodule

[tb/sv/cylinder_cylinder_push_out_unit_tb.sv]
// ----------------------------------------------------------------------------
// cylinder_cylinder_push_out_unit_tb: self-checking bench for the push-out unit
// Streams cylinder pairs through the valid/ready input, predicts resolved
// positions with an exact wide-integer model of the collision math or takes a
// typed expectation, and compares each output transaction in order. A directed table covers
// extremes, misses, coincident centers and saturation. Random pairs follow,
// mostly near-contact pairs, under several idle and stall patterns and one
// long output hold-off.
// ----------------------------------------------------------------------------
module cylinder_cylinder_push_out_unit_tb import ccpo_pkg::*; ();

	localparam int WDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [W-1:0] ax, ay, az, bx, by, bz;
		logic [W-2:0]        ar, ah, br, bh;
	} pair_t;

	typedef struct {
		logic                hit;
		logic signed [W-1:0] x, y, z;
	} pos_t;

	typedef struct {
		pair_t p;
		bit    fixed;
		pos_t  want;
	} row_t;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	logic signed [W-1:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	logic [W-2:0]        a_radius = 0, a_height = 0, b_radius = 0, b_height = 0;
	logic                out_valid;
	logic                out_ready = 0;
	logic                hit;
	logic signed [W-1:0] out_x, out_y, out_z;

	pos_t expected_pos[$];
	int   fail_count = 0;
	int   snd_idle = 0;
	int   rcv_stall = 0;
	bit   hold_req = 0;
	int   quiet_cycles = 0;

	cylinder_cylinder_push_out_unit dut (.*);

	always #5 clk = ~clk;

	// Exact collision resolution in wide integers.
	function automatic pos_t resolve(pair_t p);
		longint ax, ay, az, bx, by, bz, dx, dz, px, pz, vx, vz;
		logic [63:0] mx, mz, rng, d, c;
		logic [127:0] s, rr, num;
		pos_t r;
		ax = p.ax; ay = p.ay; az = p.az;
		bx = p.bx; by = p.by; bz = p.bz;
		r.hit = 0;
		r.x = p.bx;
		r.y = p.by;
		r.z = p.bz;
		if (ay > by + longint'(p.bh) || ay + longint'(p.ah) < by)
			return r;
		dx = bx - ax;
		dz = bz - az;
		mx = dx < 0 ? -dx : dx;
		mz = dz < 0 ? -dz : dz;
		rng = 64'(p.ar) + 64'(p.br);
		s = 128'(mx) * 128'(mx) + 128'(mz) * 128'(mz);
		rr = 128'(rng) * 128'(rng);
		if (s > rr)
			return r;
		if (dx == 0 && dz == 0) begin
			px = rng;
			pz = 0;
		end else begin
			d = 0;
			for (int i = 50; i >= 0; i--) begin
				c = d | (64'd1 << i);
				if (128'(c) * 128'(c) <= s)
					d = c;
			end
			num = (128'(mx) * 128'(rng) + 128'(d >> 1)) / 128'(d);
			px = dx < 0 ? -longint'(num[63:0]) : longint'(num[63:0]);
			num = (128'(mz) * 128'(rng) + 128'(d >> 1)) / 128'(d);
			pz = dz < 0 ? -longint'(num[63:0]) : longint'(num[63:0]);
		end
		vx = ax + px;
		vz = az + pz;
		// Saturate to the signed coordinate range.
		if (vx > 64'sh7fffffff) vx = 64'sh7fffffff;
		if (vx < -64'sh80000000) vx = -64'sh80000000;
		if (vz > 64'sh7fffffff) vz = 64'sh7fffffff;
		if (vz < -64'sh80000000) vz = -64'sh80000000;
		r.hit = 1;
		r.x = vx[W-1:0];
		r.z = vz[W-1:0];
		return r;
	endfunction

	// Random pair: mostly near-contact pairs, some fully random ones.
	function automatic pair_t random_pair();
		pair_t p;
		int span;
		p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
		p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
		p.ar = (W-1)'($urandom); p.ah = (W-1)'($urandom);
		p.br = (W-1)'($urandom); p.bh = (W-1)'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			span = 1 << $urandom_range(2, 29);
			p.bx = p.ax + $signed($urandom_range(0, 2 * span)) - span;
			p.bz = p.az + $signed($urandom_range(0, 2 * span)) - span;
			p.ar = (W-1)'($urandom_range(0, span));
			p.br = (W-1)'($urandom_range(0, span));
			p.by = p.ay + $signed($urandom_range(0, 2 * span)) - span;
			p.ah = (W-1)'($urandom_range(0, 2 * span));
			p.bh = (W-1)'($urandom_range(0, 2 * span));
			if ($urandom_range(0, 15) == 0) begin
				p.bx = p.ax;
				p.bz = p.az;
			end
		end
		return p;
	endfunction

	// Offer one transaction and wait until it is accepted.
	task automatic send_pair(pair_t p, pos_t want);
		while ($urandom_range(1, 100) <= snd_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		a_x <= p.ax; a_y <= p.ay; a_z <= p.az; a_radius <= p.ar; a_height <= p.ah;
		b_x <= p.bx; b_y <= p.by; b_z <= p.bz; b_radius <= p.br; b_height <= p.bh;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		expected_pos.push_back(want);
	endtask

	// Output side: random stalls, long hold-off on request, in-order check.
	initial begin
		int held;
		pos_t e;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_pos.size() == 0) begin
					$display("%0t: unexpected output transaction hit=%0b x=%0d z=%0d",
						$time, hit, out_x, out_z);
					fail_count++;
				end else begin
					e = expected_pos.pop_front();
					if (hit !== e.hit || out_x !== e.x || out_y !== e.y || out_z !== e.z) begin
						$display("%0t: mismatch expected hit=%0b x=%0d y=%0d z=%0d",
							$time, e.hit, e.x, e.y, e.z);
						$display("%0t:          actual   hit=%0b x=%0d y=%0d z=%0d",
							$time, hit, out_x, out_y, out_z);
						fail_count++;
					end
				end
			end
			if (hold_req) begin
				held++;
				out_ready <= 0;
				if (held >= HOLD_CYCLES) begin
					hold_req = 0;
					held = 0;
				end
			end else begin
				out_ready <= ($urandom_range(1, 100) > rcv_stall);
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT && arst_n) begin
			$display("%0t: watchdog timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		pair_t p;
		pos_t none;
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 86, 0, 37};
		stall_set = '{0, 0, 86, 37};
		none = '{0, 0, 0, 0};

		// Directed table: pair, typed expectation flag, expectation.
		// All zero: coincident centers with zero radius.
		rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0}});
		// Coincident centers push B by the summed radius along +x.
		rows.push_back('{'{32'sh10000, 32'sh20000, 32'sh30000, 32'sh10000, 32'sh20000,
			32'sh30000, 31'h10000, 31'h10000, 31'h20000, 31'h10000}, 1,
			'{1, 32'sh40000, 32'sh20000, 32'sh30000}});
		// B entirely above A: height miss, B unchanged.
		rows.push_back('{'{0, 0, 0, 0, 32'sh100000, 0, 31'h10000, 31'h10000, 31'h10000,
			31'h10000}, 1, '{0, 0, 32'sh100000, 0}});
		// Far apart in XZ: distance miss.
		rows.push_back('{'{0, 0, 0, 32'sh500000, 0, 32'sh500000, 31'h10000, 31'h10000,
			31'h10000, 31'h10000}, 1, '{0, 32'sh500000, 0, 32'sh500000}});
		// Exactly touching along x.
		rows.push_back('{'{0, 0, 0, 32'sh30000, 0, 0, 31'h10000, 31'h10000, 31'h20000,
			31'h10000}, 1, '{1, 32'sh30000, 0, 0}});
		// Coincident at the top of the range saturates high.
		rows.push_back('{'{32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0, 31'h7fffffff, 0,
			31'h7fffffff, 0}, 1, '{1, 32'sh7fffffff, 0, 0}});
		// Pushed toward the bottom of the range saturates low.
		rows.push_back('{'{-32'sh7fffffff, 0, 0, -32'sh80000000, 0, 0, 31'h7fffffff, 0,
			31'h7fffffff, 0}, 1, '{1, -32'sh80000000, 0, 0}});
		// Feet just touching in height.
		rows.push_back('{'{0, 0, 0, 32'sh8000, 32'sh10000, 0, 31'h10000, 31'h10000,
			31'h10000, 0}, 0, none});
		// 3-4-5 diagonal, negative z.
		rows.push_back('{'{0, 0, 0, 32'sh30000, 0, -32'sh40000, 31'h30000, 31'h10000,
			31'h50000, 31'h10000}, 0, none});
		// Field maxima everywhere.
		rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			31'h7fffffff}, 0, none});
		// Opposite corners with maximal radii.
		rows.push_back('{'{-32'sh80000000, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff,
			-32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			31'h7fffffff}, 0, none});
		// Small odd offsets exercise the rounding.
		rows.push_back('{'{5, 0, -7, 8, 0, -3, 31'd3, 31'd1, 31'd4, 31'd1}, 0, none});
		rows.push_back('{'{0, 0, 0, -1, 0, 1, 31'd1, 31'd0, 31'd1, 31'd0}, 0, none});

		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			rw = rows[i];
			send_pair(rw.p, rw.fixed ? rw.want : resolve(rw.p));
		end

		// Random pairs under each idle and stall pattern.
		for (int ph = 0; ph < 4; ph++) begin
			snd_idle = idle_set[ph];
			rcv_stall = stall_set[ph];
			repeat (260) begin
				p = random_pair();
				send_pair(p, resolve(p));
			end
		end

		// Long output hold-off while input keeps streaming, to fill the pipe.
		snd_idle = 0;
		rcv_stall = 0;
		hold_req = 1;
		repeat (150) begin
			p = random_pair();
			send_pair(p, resolve(p));
		end
		in_valid <= 0;

		while (expected_pos.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
